// ----- rtl/rpq_pkg.sv -----
package rpq_pkg;

  // fixed field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned TaskW   = 4;
  localparam int unsigned PrioW   = 3;
  localparam int unsigned StatusW = 3;

  // default configuration
  localparam int unsigned DefDepth          = 16;
  localparam int unsigned DefPriorityLevels = 8;

  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE    = 2'd0,
    OP_DEQUEUE    = 2'd1,
    OP_REPRIORITY = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // one input item
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] task_priority;
    logic             task_blocked;
  } in_t;

  // one result item
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TaskW-1:0]   head_task;
    logic               head_valid;
  } out_t;

  // contents of one list slot
  typedef struct packed {
    logic [TaskW-1:0] tid;
    logic [PrioW-1:0] prio;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [TaskW-1:0] tid;
    logic [PrioW-1:0] prio;
  } cell_cmd_t;

endpackage

// ----- rtl/rpq_cell.sv -----
module rpq_cell (
  input  logic               clk_i,
  input  rpq_pkg::cell_cmd_t cmd_i,
  input  logic               occ_i,
  input  rpq_pkg::slot_t     left_i,
  input  logic               left_le_i,
  input  rpq_pkg::slot_t     right_i,
  input  logic               hit_i,
  output rpq_pkg::slot_t     slot_o,
  output logic               le_o,
  output logic               match_o,
  output logic               same_o,
  output logic               hit_o
);

  rpq_pkg::slot_t slot_q;
  rpq_pkg::slot_t slot_d;

  // compare against the broadcast key
  always_comb begin
    le_o    = occ_i && (slot_q.prio <= cmd_i.prio);
    match_o = occ_i && (slot_q.tid == cmd_i.tid);
    same_o  = match_o && (slot_q.prio == cmd_i.prio);
    hit_o   = hit_i | match_o;
  end

  // insert shifts right past the sorted prefix, remove pulls from the right
  always_comb begin
    slot_d = slot_q;
    if (cmd_i.ins) begin
      if (!le_o) begin
        if (left_le_i) begin
          slot_d.tid  = cmd_i.tid;
          slot_d.prio = cmd_i.prio;
        end else begin
          slot_d = left_i;
        end
      end
    end else if (cmd_i.rem && hit_o) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ----- rtl/ready_priority_queue.sv -----
// Ready list of task ids kept sorted by priority (lower value first, first in
// first out among equal priorities) in a chain of DEPTH cells; each cell
// compares its own entry with the broadcast key and takes its data from
// itself, the key, its left or its right neighbor. An item is accepted when
// start is high and busy is low; enqueue, dequeue and every rejected item
// make a single pass through the chain, a reprioritize that moves a task
// makes two (one to remove, one to insert). The result appears in the cycle
// after the last pass as a single-cycle strobe on res_valid_o with res_o;
// there is no backpressure, so the receiver must take it in that cycle. A
// new item may be started in the cycle the result is shown.
module ready_priority_queue #(
  parameter int unsigned DEPTH           = rpq_pkg::DefDepth,
  parameter int unsigned PRIORITY_LEVELS = rpq_pkg::DefPriorityLevels
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rpq_pkg::in_t  req_i,
  output logic          busy,
  output logic          res_valid_o,
  output rpq_pkg::out_t res_o
);

  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned ClampMax =
    (PRIORITY_LEVELS - 1 > 7) ? 7 : PRIORITY_LEVELS - 1;
  localparam logic [rpq_pkg::PrioW-1:0] PrioMax = ClampMax[rpq_pkg::PrioW-1:0];

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_INSERT = 3'b100
  } state_e;

  state_e             state_q, state_d;
  rpq_pkg::in_t       req_q;
  rpq_pkg::in_t       req_clamp;
  logic [CntW-1:0]    count_q, count_d;
  rpq_pkg::out_t      res_q, res_d;
  logic               res_valid_q, res_valid_d;
  rpq_pkg::cell_cmd_t cmd;
  logic               seed;

  rpq_pkg::slot_t     slot_w [DEPTH];
  logic [DEPTH-1:0]   occ_w, le_w, match_w, same_w;
  logic [DEPTH:0]     hit_w;

  logic               accept, full, empty, dup, same_prio;

  assign accept    = start && !busy;
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign dup       = hit_w[DEPTH];
  assign same_prio = |same_w;
  assign busy      = (state_q != S_IDLE);

  // dequeue removes from the head: seed the remove chain at cell zero
  assign seed     = (state_q == S_EXEC) &&
                    (req_q.op == rpq_pkg::OP_DEQUEUE);
  assign hit_w[0] = seed;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rpq_pkg::slot_t left_s, right_s;
    logic           left_le;

    assign occ_w[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_s  = '0;
      assign left_le = 1'b1;
    end else begin : g_body
      assign left_s  = slot_w[i-1];
      assign left_le = le_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_mid
      assign right_s = slot_w[i+1];
    end

    rpq_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .occ_i     (occ_w[i]),
      .left_i    (left_s),
      .left_le_i (left_le),
      .right_i   (right_s),
      .hit_i     (hit_w[i]),
      .slot_o    (slot_w[i]),
      .le_o      (le_w[i]),
      .match_o   (match_w[i]),
      .same_o    (same_w[i]),
      .hit_o     (hit_w[i+1])
    );
  end

  // sequencer: decide the chain command and the result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    cmd.ins     = 1'b0;
    cmd.rem     = 1'b0;
    cmd.tid     = req_q.task_id;
    cmd.prio    = req_q.task_priority;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d          = S_IDLE;
        res_valid_d      = 1'b1;
        res_d.status     = rpq_pkg::ST_OK;
        res_d.head_task  = '0;
        res_d.head_valid = 1'b0;
        case (req_q.op)
          rpq_pkg::OP_ENQUEUE: begin
            if (req_q.task_blocked || dup) begin
              res_d.status = rpq_pkg::ST_IGNORED;
            end else if (full) begin
              res_d.status = rpq_pkg::ST_FULL;
            end else begin
              cmd.ins = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          rpq_pkg::OP_DEQUEUE: begin
            if (empty) begin
              res_d.status = rpq_pkg::ST_EMPTY;
            end else begin
              cmd.rem          = 1'b1;
              count_d          = count_q - 1'b1;
              res_d.head_task  = slot_w[0].tid;
              res_d.head_valid = 1'b1;
            end
          end
          rpq_pkg::OP_REPRIORITY: begin
            if (!dup) begin
              res_d.status = rpq_pkg::ST_NOT_FOUND;
            end else if (!same_prio) begin
              // pull the task out now, insert it on the next pass
              cmd.rem     = 1'b1;
              count_d     = count_q - 1'b1;
              res_valid_d = 1'b0;
              state_d     = S_INSERT;
            end
          end
          default: begin
            res_d.status = rpq_pkg::ST_IGNORED;
          end
        endcase
      end
      S_INSERT: begin
        cmd.ins          = 1'b1;
        count_d          = count_q + 1'b1;
        state_d          = S_IDLE;
        res_valid_d      = 1'b1;
        res_d.status     = rpq_pkg::ST_OK;
        res_d.head_task  = '0;
        res_d.head_valid = 1'b0;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // priority clamp of the incoming item
  always_comb begin
    req_clamp = req_i;
    if (req_i.task_priority > PrioMax) begin
      req_clamp.task_priority = PrioMax;
    end
  end

  // item capture, result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_clamp;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // the list never holds more than DEPTH entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  // a result only follows a pass through the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == S_EXEC || $past(state_q) == S_INSERT))
    else $error("result without execution");

  // a popped head always comes with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.head_valid) |-> (res_o.status == rpq_pkg::ST_OK))
    else $error("popped head with error status");

  // a task id appears at most once in the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(match_w))
    else $error("duplicate task in list");

  // an accepted item is executed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned Depth       = rpq_pkg::DefDepth;
  localparam int unsigned PrioLevels  = rpq_pkg::DefPriorityLevels;
  localparam int unsigned IdleLimit   = 500;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 700;

  // op encoding the block does not define
  localparam logic [rpq_pkg::OpW-1:0] OpUnused = 2'd3;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  rpq_pkg::in_t  req_i  = '0;
  logic          busy;
  logic          res_valid_o;
  rpq_pkg::out_t res_o;

  // predicted list contents, head at index 0
  rpq_pkg::slot_t ready_list[$];
  // outcomes of accepted commands not yet seen on the result port
  rpq_pkg::out_t  pending_outcomes[$];
  rpq_pkg::out_t  oldest_outcome;
  int             mismatch_count = 0;
  int             idle_cycles    = 0;
  bit             no_idle        = 1'b0;

  ready_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int find_listed(input logic [rpq_pkg::TaskW-1:0] tid);
    foreach (ready_list[i]) begin
      if (ready_list[i].tid == tid) return i;
    end
    return -1;
  endfunction

  // place after every entry of equal or better priority
  function automatic void insert_by_priority(input rpq_pkg::slot_t entry);
    int pos;
    pos = 0;
    while (pos < ready_list.size() && ready_list[pos].prio <= entry.prio) pos++;
    ready_list.insert(pos, entry);
  endfunction

  // apply one command to the predicted list and return its outcome
  function automatic rpq_pkg::out_t predict_ready_list(input rpq_pkg::in_t cmd);
    rpq_pkg::out_t             res;
    rpq_pkg::slot_t            entry;
    rpq_pkg::slot_t            head;
    int                        pos;
    logic [rpq_pkg::PrioW-1:0] prio;
    res = '0;
    res.status = rpq_pkg::ST_OK;
    prio = (cmd.task_priority >= PrioLevels) ? rpq_pkg::PrioW'(PrioLevels - 1)
                                              : cmd.task_priority;
    entry.tid  = cmd.task_id;
    entry.prio = prio;
    case (cmd.op)
      rpq_pkg::OP_ENQUEUE: begin
        if (cmd.task_blocked || find_listed(cmd.task_id) >= 0) res.status = rpq_pkg::ST_IGNORED;
        else if (ready_list.size() >= Depth) res.status = rpq_pkg::ST_FULL;
        else insert_by_priority(entry);
      end
      rpq_pkg::OP_DEQUEUE: begin
        if (ready_list.size() == 0) begin
          res.status = rpq_pkg::ST_EMPTY;
        end else begin
          head           = ready_list.pop_front();
          res.head_task  = head.tid;
          res.head_valid = 1'b1;
        end
      end
      rpq_pkg::OP_REPRIORITY: begin
        pos = find_listed(cmd.task_id);
        if (pos < 0) begin
          res.status = rpq_pkg::ST_NOT_FOUND;
        end else if (ready_list[pos].prio != prio) begin
          ready_list.delete(pos);
          insert_by_priority(entry);
        end
      end
      default: res.status = rpq_pkg::ST_IGNORED;
    endcase
    return res;
  endfunction

  function automatic rpq_pkg::in_t make_cmd(input logic [rpq_pkg::OpW-1:0] op,
                                            input logic [rpq_pkg::TaskW-1:0] tid,
                                            input logic [rpq_pkg::PrioW-1:0] prio,
                                            input logic blocked);
    rpq_pkg::in_t cmd;
    cmd.op            = op;
    cmd.task_id       = tid;
    cmd.task_priority = prio;
    cmd.task_blocked  = blocked;
    return cmd;
  endfunction

  // present one command and hold it until the block takes it
  task automatic issue_command(input rpq_pkg::in_t cmd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= cmd;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_outcomes.push_back(predict_ready_list(cmd));
  endtask

  // empty list, blocked and duplicate enqueue, fifo among equals, moves, bad op
  task automatic test_corner_cases();
    issue_command(make_cmd(rpq_pkg::OP_DEQUEUE, 4'd0, 3'd0, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_REPRIORITY, 4'd3, 3'd1, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, 4'd9, 3'd2, 1'b1));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, 4'd15, 3'd7, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, 4'd0, 3'd0, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, 4'd15, 3'd3, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, 4'd5, 3'd7, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, 4'd10, 3'd0, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_REPRIORITY, 4'd15, 3'd7, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_REPRIORITY, 4'd5, 3'd0, 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_REPRIORITY, 4'd0, 3'd7, 1'b1));
    issue_command(make_cmd(OpUnused, 4'd15, 3'd7, 1'b1));
    issue_command(make_cmd(rpq_pkg::OP_DEQUEUE, 4'd15, 3'd7, 1'b1));
    repeat (4) issue_command(make_cmd(rpq_pkg::OP_DEQUEUE, 4'd0, 3'd0, 1'b0));
  endtask

  // every id listed at once, then an enqueue against the full list, reprioritizes and dequeues past empty
  task automatic test_full_list();
    logic [rpq_pkg::TaskW-1:0] ids[Depth];
    logic [rpq_pkg::TaskW-1:0] swap;
    int                        j;
    for (int i = 0; i < Depth; i++) ids[i] = rpq_pkg::TaskW'(i);
    for (int i = Depth - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = ids[i];
      ids[i] = ids[j];
      ids[j] = swap;
    end
    foreach (ids[i]) issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, ids[i],
                                            rpq_pkg::PrioW'($urandom), 1'b0));
    issue_command(make_cmd(rpq_pkg::OP_ENQUEUE, rpq_pkg::TaskW'($urandom),
                           rpq_pkg::PrioW'($urandom), 1'b0));
    repeat (4) issue_command(make_cmd(rpq_pkg::OP_REPRIORITY, rpq_pkg::TaskW'($urandom),
                                      rpq_pkg::PrioW'($urandom), 1'b0));
    repeat (Depth + 1) issue_command(make_cmd(rpq_pkg::OP_DEQUEUE, rpq_pkg::TaskW'($urandom),
                                              rpq_pkg::PrioW'($urandom), 1'($urandom)));
  endtask

  // alternating fill and drain phases, reprioritize mostly of listed tasks
  task automatic test_random_traffic();
    rpq_pkg::in_t cmd;
    int           roll;
    int           enq_weight;
    for (int n = 0; n < RandomItems; n++) begin
      enq_weight = ((n / 50) % 2 == 0) ? 50 : 25;
      no_idle = ((n / 25) % 4 == 3);
      cmd.task_id       = rpq_pkg::TaskW'($urandom);
      cmd.task_priority = rpq_pkg::PrioW'($urandom);
      cmd.task_blocked  = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < enq_weight) begin
        cmd.op = rpq_pkg::OP_ENQUEUE;
        cmd.task_blocked = ($urandom_range(0, 9) == 0);
      end else if (roll < 70) begin
        cmd.op = rpq_pkg::OP_DEQUEUE;
      end else if (roll < 94) begin
        cmd.op = rpq_pkg::OP_REPRIORITY;
        if (ready_list.size() != 0 && $urandom_range(0, 4) != 0)
          cmd.task_id = ready_list[$urandom_range(0, ready_list.size() - 1)].tid;
      end else begin
        cmd.op = OpUnused;
      end
      issue_command(cmd);
    end
    no_idle = 1'b0;
  endtask

  // compare each result strobe with the oldest pending outcome
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no command pending");
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (res_o.status !== oldest_outcome.status)
          report_mismatch($sformatf("status got %0d want %0d", res_o.status,
                                    oldest_outcome.status));
        if (res_o.head_task !== oldest_outcome.head_task)
          report_mismatch($sformatf("head_task got %0d want %0d", res_o.head_task,
                                    oldest_outcome.head_task));
        if (res_o.head_valid !== oldest_outcome.head_valid)
          report_mismatch($sformatf("head_valid got %0b want %0b", res_o.head_valid,
                                    oldest_outcome.head_valid));
      end
    end
  end

  // stop a hung run: too long with neither a command nor a result taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || res_valid_o === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_full_list();
    test_random_traffic();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
